>>> hdl/punch_card_column_decoder_defines.svh
// Assertion macros for the punch card column decoder.
`ifndef PUNCH_CARD_COLUMN_DECODER_DEFINES_SVH
`define PUNCH_CARD_COLUMN_DECODER_DEFINES_SVH
`ifndef ASSERT_OFF
`define PCD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcd assertion failed");
`define PCD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcd assertion failed");
`else
`define PCD_ASSERT_IMP(label, clk, rst, ante, cons)
`define PCD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hdl/pcd_pkg.sv
// Shared types and constants of the punch card column decoder.
`default_nettype none
package pcd_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int ADDR_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1) + 1;
   localparam int ROW_W         = 12;
   localparam int ENTRY_W       = 6;
   localparam int CHAR_W        = 8;
   localparam int KIND_W        = 2;

   localparam logic [ROW_W-1:0]  ALL_ROWS    = '1;
   localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_WRITE  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      DEC_NONE,
      DEC_START,
      DEC_DECODE,
      DEC_FINISH
   } decision_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic scan_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic         is_write;
      decision_type decision;
      logic         scan_done;
   } status_type;

endpackage
`default_nettype wire

>>> hdl/pcd_ctrl.sv
// Controller state machine of the punch card column decoder.
`default_nettype none
module pcd_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire pcd_pkg::status_type status,
   output pcd_pkg::cmd_type        cmd
);

   pcd_pkg::state_type state_ff;
   pcd_pkg::state_type state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         pcd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = pcd_pkg::ST_EXEC;
            end
         end
         pcd_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.is_write) begin
               state_in = pcd_pkg::ST_IDLE;
            end else begin
               case (status.decision)
                  pcd_pkg::DEC_NONE:   state_in = pcd_pkg::ST_IDLE;
                  pcd_pkg::DEC_DECODE: state_in = pcd_pkg::ST_SCAN;
                  default:             state_in = pcd_pkg::ST_EMIT;
               endcase
            end
         end
         pcd_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               state_in = pcd_pkg::ST_EMIT;
            end
         end
         pcd_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = pcd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pcd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

>>> hdl/pcd_datapath.sv
// Datapath of the punch card column decoder: sensor state, code table and scan.
`default_nettype none
module pcd_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pcd_pkg::cmd_type              cmd,
   output pcd_pkg::status_type                status,
   input  wire logic                          req_type,
   input  wire logic [pcd_pkg::ROW_W-1:0]     req_rows_active,
   input  wire logic [pcd_pkg::ENTRY_W-1:0]   req_entry_index,
   input  wire logic [pcd_pkg::ROW_W-1:0]     req_entry_pattern,
   input  wire logic [pcd_pkg::CHAR_W-1:0]    req_entry_char,
   output logic      [pcd_pkg::KIND_W-1:0]    rsp_event_kind,
   output logic      [pcd_pkg::CHAR_W-1:0]    rsp_char_code
);

   logic                          type_ff;
   logic [pcd_pkg::ROW_W-1:0]     rows_ff;
   logic [pcd_pkg::CNT_W-1:0]     wr_addr_ff;
   logic [pcd_pkg::ROW_W-1:0]     wr_pat_ff;
   logic [pcd_pkg::CHAR_W-1:0]    wr_chr_ff;

   logic [pcd_pkg::ROW_W-1:0]     accum_ff;
   logic [pcd_pkg::ROW_W-1:0]     accum_in;
   logic                          seen_act_ff;
   logic                          seen_act_in;
   logic                          seen_clr_ff;
   logic                          seen_clr_in;
   logic                          card_ff;
   logic                          card_in;
   logic [pcd_pkg::ROW_W-1:0]     key_ff;
   pcd_pkg::decision_type         decision;

   logic [pcd_pkg::ROW_W-1:0]     table_pat_ff [pcd_pkg::TABLE_ENTRIES];
   logic [pcd_pkg::CHAR_W-1:0]    table_chr_ff [pcd_pkg::TABLE_ENTRIES];
   logic [pcd_pkg::TABLE_ENTRIES-1:0] vld_ff;
   logic                          wr_en;

   logic [pcd_pkg::CNT_W-1:0]     addr_ff;
   logic                          addr_live;
   logic                          rd_live_ff;
   logic [pcd_pkg::ROW_W-1:0]     rd_pat_ff;
   logic [pcd_pkg::CHAR_W-1:0]    rd_chr_ff;
   logic                          rd_vld_ff;
   logic [pcd_pkg::ROW_W-1:0]     eff_pat;
   logic [pcd_pkg::CHAR_W-1:0]    eff_chr;
   logic                          match_now;

   logic [pcd_pkg::KIND_W-1:0]    res_kind_ff;
   logic [pcd_pkg::CHAR_W-1:0]    res_chr_ff;
   logic [pcd_pkg::KIND_W-1:0]    out_kind_ff;
   logic [pcd_pkg::CHAR_W-1:0]    out_chr_ff;

   // hold the accepted transaction
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff    <= req_type;
         rows_ff    <= req_rows_active;
         wr_addr_ff <= pcd_pkg::CNT_W'(req_entry_index);
         wr_pat_ff  <= req_entry_pattern;
         wr_chr_ff  <= req_entry_char;
      end
   end

   always_comb begin
      accum_in    = accum_ff | rows_ff;
      seen_act_in = seen_act_ff;
      seen_clr_in = seen_clr_ff;
      card_in     = card_ff;
      decision    = pcd_pkg::DEC_NONE;
      if (rows_ff == pcd_pkg::ALL_ROWS) begin
         if (!seen_act_ff) begin
            decision = pcd_pkg::DEC_FINISH;
            card_in  = 1'b0;
         end
         seen_act_in = 1'b1;
      end else if (rows_ff == '0) begin
         seen_clr_in = 1'b1;
         if (!card_ff) begin
            decision    = pcd_pkg::DEC_START;
            card_in     = 1'b1;
            accum_in    = '0;
            seen_act_in = 1'b0;
         end else if (!seen_clr_ff) begin
            decision    = pcd_pkg::DEC_DECODE;
            accum_in    = '0;
            seen_act_in = 1'b0;
         end
      end else begin
         seen_act_in = 1'b0;
         seen_clr_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff    <= '0;
         seen_act_ff <= 1'b0;
         seen_clr_ff <= 1'b0;
         card_ff     <= 1'b0;
      end else if (cmd.exec && type_ff == pcd_pkg::REQ_SAMPLE) begin
         accum_ff    <= accum_in;
         seen_act_ff <= seen_act_in;
         seen_clr_ff <= seen_clr_in;
         card_ff     <= card_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         key_ff <= accum_ff;
      end
   end

   assign wr_en = cmd.exec && type_ff == pcd_pkg::REQ_WRITE &&
                  wr_addr_ff < pcd_pkg::CNT_W'(pcd_pkg::TABLE_ENTRIES);

   assign addr_live = addr_ff < pcd_pkg::CNT_W'(pcd_pkg::TABLE_ENTRIES);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_pat_ff[wr_addr_ff[pcd_pkg::ADDR_W-1:0]] <= wr_pat_ff;
         table_chr_ff[wr_addr_ff[pcd_pkg::ADDR_W-1:0]] <= wr_chr_ff;
      end
      if (cmd.scan_step && addr_live) begin
         rd_pat_ff <= table_pat_ff[addr_ff[pcd_pkg::ADDR_W-1:0]];
         rd_chr_ff <= table_chr_ff[addr_ff[pcd_pkg::ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr_ff[pcd_pkg::ADDR_W-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff    <= '0;
         rd_live_ff <= 1'b0;
      end else if (cmd.exec) begin
         addr_ff    <= '0;
         rd_live_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         rd_live_ff <= addr_live;
         if (addr_live) begin
            addr_ff   <= addr_ff + pcd_pkg::CNT_W'(1);
            rd_vld_ff <= vld_ff[addr_ff[pcd_pkg::ADDR_W-1:0]];
         end
      end
   end

   assign eff_pat   = rd_vld_ff ? rd_pat_ff : '0;
   assign eff_chr   = rd_vld_ff ? rd_chr_ff : '0;
   assign match_now = rd_live_ff && (eff_pat == key_ff);

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         res_chr_ff <= '0;
         case (decision)
            pcd_pkg::DEC_START:  res_kind_ff <= pcd_pkg::KIND_START;
            pcd_pkg::DEC_FINISH: res_kind_ff <= pcd_pkg::KIND_FINISH;
            default:             res_kind_ff <= pcd_pkg::KIND_CHAR;
         endcase
      end else if (cmd.scan_step && match_now) begin
         res_chr_ff <= eff_chr;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_kind_ff <= res_kind_ff;
         out_chr_ff  <= res_chr_ff;
      end
   end

   assign status.is_write  = (type_ff == pcd_pkg::REQ_WRITE);
   assign status.decision  = decision;
   assign status.scan_done = match_now || (!addr_live && !rd_live_ff);

   assign rsp_event_kind = out_kind_ff;
   assign rsp_char_code  = out_chr_ff;

endmodule
`default_nettype wire

>>> hdl/punch_card_column_decoder.sv
// Top level of the punch card column decoder.
// A sample of the twelve row sensors or a code table write is taken when req_valid and
// req_ready are both high; at most one result (card started, character, card finished)
// follows on the rsp_ channel. A sample that closes a column scans the code table
// one entry a cycle through its registered read port, lowest index first, stopping at the
// first match. The result waits in an output register, so the next transaction is taken while
// it is still unread. The table reads as all zero after reset without a clearing pass.
`default_nettype none
`include "punch_card_column_decoder_defines.svh"
module punch_card_column_decoder (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_type,
   input  wire logic [pcd_pkg::ROW_W-1:0]     req_rows_active,
   input  wire logic [pcd_pkg::ENTRY_W-1:0]   req_entry_index,
   input  wire logic [pcd_pkg::ROW_W-1:0]     req_entry_pattern,
   input  wire logic [pcd_pkg::CHAR_W-1:0]    req_entry_char,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [pcd_pkg::KIND_W-1:0]    rsp_event_kind,
   output logic      [pcd_pkg::CHAR_W-1:0]    rsp_char_code
);

   pcd_pkg::cmd_type    cmd;
   pcd_pkg::status_type status;

   pcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pcd_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_type          (req_type),
      .req_rows_active   (req_rows_active),
      .req_entry_index   (req_entry_index),
      .req_entry_pattern (req_entry_pattern),
      .req_entry_char    (req_entry_char),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_char_code     (rsp_char_code)
   );

   `PCD_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `PCD_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.load_out, !rsp_valid || rsp_ready)
   `PCD_ASSERT_IMP(a_char_only_decoded, clock, reset,
                   rsp_valid && rsp_event_kind != pcd_pkg::KIND_CHAR, rsp_char_code == '0)

endmodule
`default_nettype wire
